FILE: src/nes_pkg.sv
// Shared types, constants and the microcode table of the note event sequencer.
// Depends on nothing; every other file but nes_if refers to it by scoped names.
`timescale 1ns / 1ps
package nes_pkg;

  localparam int unsigned EVENT_DEPTH  = 4096;
  localparam int unsigned MAX_PER_TICK = 64;
  localparam int unsigned PTR_W        = $clog2(EVENT_DEPTH);
  localparam int unsigned CNT_W        = $clog2(MAX_PER_TICK + 1);
  localparam int unsigned STEP_W       = 5;

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(EVENT_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_PER_TICK);

  localparam logic [7:0] END_VEL   = 8'hFF;
  localparam logic [7:0] VEL_CLAMP = 8'hFE;

  localparam logic [2:0] FUNC_TICK       = 3'd0;
  localparam logic [2:0] FUNC_KEY        = 3'd1;
  localparam logic [2:0] FUNC_START_REC  = 3'd2;
  localparam logic [2:0] FUNC_END_REC    = 3'd3;
  localparam logic [2:0] FUNC_STOP       = 3'd4;
  localparam logic [2:0] FUNC_START_PLAY = 3'd5;

  localparam logic [2:0] KIND_NOTE_ON  = 3'd0;
  localparam logic [2:0] KIND_NOTE_OFF = 3'd1;
  localparam logic [2:0] KIND_WRAP     = 3'd2;
  localparam logic [2:0] KIND_FULL     = 3'd3;
  localparam logic [2:0] KIND_DROP     = 3'd4;

  typedef enum logic [1:0] {
    MODE_STOP   = 2'd0,
    MODE_RECORD = 2'd1,
    MODE_PLAY   = 2'd2
  } mode_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_TICK_REC,
    OP_ZERO_CP,
    OP_START_REC,
    OP_STOP,
    OP_START_PLAY,
    OP_WR_END,
    OP_WR_KEY,
    OP_EMIT_FULL,
    OP_EMIT_DROP,
    OP_PLAY_INIT,
    OP_READ,
    OP_PUSH_NOTE,
    OP_CLK_INC,
    OP_FLUSH_LAST,
    OP_FLUSH_MID,
    OP_EMIT_WRAP
  } op_e;

  typedef enum logic [3:0] {
    C_NEXT,
    C_JUMP,
    C_DISPATCH,
    C_IF_DROP,
    C_IF_NOT_FULL,
    C_IF_BUDGET,
    C_IF_MISS,
    C_IF_END,
    C_IF_MATCH
  } cond_e;

  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic [STEP_W-1:0] target;
  } uword_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    logic  stall;
    logic  drop;
    logic  full;
    logic  budget;
    logic  match;
    logic  is_end;
    logic  seq_present;
    mode_e mode;
  } flags_t;

  localparam logic [STEP_W-1:0] ST_IDLE       = 5'd0;
  localparam logic [STEP_W-1:0] ST_TICK_REC   = 5'd1;
  localparam logic [STEP_W-1:0] ST_TICK_STOP  = 5'd2;
  localparam logic [STEP_W-1:0] ST_START_REC  = 5'd3;
  localparam logic [STEP_W-1:0] ST_STOP       = 5'd4;
  localparam logic [STEP_W-1:0] ST_START_PLAY = 5'd5;
  localparam logic [STEP_W-1:0] ST_END_REC    = 5'd6;
  localparam logic [STEP_W-1:0] ST_KEY        = 5'd7;
  localparam logic [STEP_W-1:0] ST_KEY_WR     = 5'd8;
  localparam logic [STEP_W-1:0] ST_KEY_CHK    = 5'd9;
  localparam logic [STEP_W-1:0] ST_KEY_END    = 5'd10;
  localparam logic [STEP_W-1:0] ST_KEY_FULL   = 5'd11;
  localparam logic [STEP_W-1:0] ST_DROP       = 5'd12;
  localparam logic [STEP_W-1:0] ST_PLAY       = 5'd13;
  localparam logic [STEP_W-1:0] ST_PLAY_RD    = 5'd14;
  localparam logic [STEP_W-1:0] ST_PLAY_EVAL  = 5'd15;
  localparam logic [STEP_W-1:0] ST_PLAY_CMP   = 5'd16;
  localparam logic [STEP_W-1:0] ST_PLAY_TYPE  = 5'd17;
  localparam logic [STEP_W-1:0] ST_PLAY_NOTE  = 5'd18;
  localparam logic [STEP_W-1:0] ST_PLAY_POST  = 5'd19;
  localparam logic [STEP_W-1:0] ST_PLAY_MISS  = 5'd20;
  localparam logic [STEP_W-1:0] ST_PLAY_FLUSH = 5'd21;
  localparam logic [STEP_W-1:0] ST_PLAY_WRAP  = 5'd22;
  localparam logic [STEP_W-1:0] ST_PLAY_WRAPO = 5'd23;

  function automatic uword_t ucode(input logic [STEP_W-1:0] step);
    uword_t w;
    w = '{op: OP_NONE, cond: C_JUMP, target: ST_IDLE};
    case (step)
      ST_IDLE:       w = '{op: OP_ACCEPT,     cond: C_DISPATCH,    target: ST_IDLE};
      ST_TICK_REC:   w = '{op: OP_TICK_REC,   cond: C_JUMP,        target: ST_IDLE};
      ST_TICK_STOP:  w = '{op: OP_ZERO_CP,    cond: C_JUMP,        target: ST_IDLE};
      ST_START_REC:  w = '{op: OP_START_REC,  cond: C_JUMP,        target: ST_IDLE};
      ST_STOP:       w = '{op: OP_STOP,       cond: C_JUMP,        target: ST_IDLE};
      ST_START_PLAY: w = '{op: OP_START_PLAY, cond: C_JUMP,        target: ST_IDLE};
      ST_END_REC:    w = '{op: OP_WR_END,     cond: C_JUMP,        target: ST_IDLE};
      ST_KEY:        w = '{op: OP_NONE,       cond: C_IF_DROP,     target: ST_DROP};
      ST_KEY_WR:     w = '{op: OP_WR_KEY,     cond: C_NEXT,        target: ST_IDLE};
      ST_KEY_CHK:    w = '{op: OP_NONE,       cond: C_IF_NOT_FULL, target: ST_IDLE};
      ST_KEY_END:    w = '{op: OP_WR_END,     cond: C_NEXT,        target: ST_IDLE};
      ST_KEY_FULL:   w = '{op: OP_EMIT_FULL,  cond: C_JUMP,        target: ST_IDLE};
      ST_DROP:       w = '{op: OP_EMIT_DROP,  cond: C_JUMP,        target: ST_IDLE};
      ST_PLAY:       w = '{op: OP_PLAY_INIT,  cond: C_NEXT,        target: ST_IDLE};
      ST_PLAY_RD:    w = '{op: OP_READ,       cond: C_NEXT,        target: ST_IDLE};
      ST_PLAY_EVAL:  w = '{op: OP_NONE,       cond: C_IF_BUDGET,   target: ST_PLAY_POST};
      ST_PLAY_CMP:   w = '{op: OP_NONE,       cond: C_IF_MISS,     target: ST_PLAY_MISS};
      ST_PLAY_TYPE:  w = '{op: OP_NONE,       cond: C_IF_END,      target: ST_PLAY_WRAP};
      ST_PLAY_NOTE:  w = '{op: OP_PUSH_NOTE,  cond: C_JUMP,        target: ST_PLAY_RD};
      ST_PLAY_POST:  w = '{op: OP_NONE,       cond: C_IF_MATCH,    target: ST_PLAY_FLUSH};
      ST_PLAY_MISS:  w = '{op: OP_CLK_INC,    cond: C_NEXT,        target: ST_IDLE};
      ST_PLAY_FLUSH: w = '{op: OP_FLUSH_LAST, cond: C_JUMP,        target: ST_IDLE};
      ST_PLAY_WRAP:  w = '{op: OP_FLUSH_MID,  cond: C_NEXT,        target: ST_IDLE};
      ST_PLAY_WRAPO: w = '{op: OP_EMIT_WRAP,  cond: C_JUMP,        target: ST_IDLE};
      default:       w = '{op: OP_NONE,       cond: C_JUMP,        target: ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

FILE: src/nes_if.sv
// Valid/ready channel interfaces for command beats in and result beats out.
// Depends on nothing.
`timescale 1ns / 1ps
interface nes_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [6:0] note;
  logic       note_on;
  logic [7:0] velocity;

  modport source (output valid, func, note, note_on, velocity, input ready);
  modport sink   (input valid, func, note, note_on, velocity, output ready);
endinterface

interface nes_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [6:0] out_note;
  logic [7:0] out_velocity;
  logic       last;

  modport source (output valid, kind, out_note, out_velocity, last, input ready);
  modport sink   (input valid, kind, out_note, out_velocity, last, output ready);
endinterface

FILE: src/nes_event_mem.sv
// Event memory: one write and one registered read per cycle at a shared address.
// Depends on nes_pkg for depth and address width.
`timescale 1ns / 1ps
module nes_event_mem (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic                      re_i,
  input  logic [nes_pkg::PTR_W-1:0] addr_i,
  input  logic [31:0]               wdata_i,
  output logic [31:0]               rdata_o
);

  logic [31:0] mem [nes_pkg::EVENT_DEPTH];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/nes_sequencer.sv
// Microcode sequencer: step counter, control word lookup and jump selection.
// Depends on nes_pkg for the control word format and the program table.
`timescale 1ns / 1ps
module nes_sequencer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [2:0]      func_i,
  input  nes_pkg::flags_t flags_i,
  output nes_pkg::op_e    op_o,
  output logic            in_ready_o
);

  logic [nes_pkg::STEP_W-1:0] step_q, step_d;
  logic [nes_pkg::STEP_W-1:0] step_inc;
  logic [nes_pkg::STEP_W-1:0] disp;
  nes_pkg::uword_t            uw;

  assign uw       = nes_pkg::ucode(step_q);
  assign step_inc = step_q + nes_pkg::STEP_W'(1);
  assign op_o     = uw.op;
  assign in_ready_o = (step_q == nes_pkg::ST_IDLE);

  always_comb begin
    disp = nes_pkg::ST_IDLE;
    case (func_i)
      nes_pkg::FUNC_TICK: begin
        case (flags_i.mode)
          nes_pkg::MODE_PLAY:   disp = nes_pkg::ST_PLAY;
          nes_pkg::MODE_RECORD: disp = nes_pkg::ST_TICK_REC;
          default:              disp = nes_pkg::ST_TICK_STOP;
        endcase
      end
      nes_pkg::FUNC_KEY: begin
        if (flags_i.mode == nes_pkg::MODE_RECORD) disp = nes_pkg::ST_KEY;
      end
      nes_pkg::FUNC_START_REC: disp = nes_pkg::ST_START_REC;
      nes_pkg::FUNC_END_REC: begin
        if (flags_i.mode == nes_pkg::MODE_RECORD) disp = nes_pkg::ST_END_REC;
      end
      nes_pkg::FUNC_STOP: disp = nes_pkg::ST_STOP;
      nes_pkg::FUNC_START_PLAY: begin
        if (flags_i.seq_present) disp = nes_pkg::ST_START_PLAY;
      end
      default: disp = nes_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    step_d = step_q;
    if (!flags_i.stall) begin
      case (uw.cond)
        nes_pkg::C_NEXT:        step_d = step_inc;
        nes_pkg::C_JUMP:        step_d = uw.target;
        nes_pkg::C_DISPATCH:    step_d = in_valid_i ? disp : nes_pkg::ST_IDLE;
        nes_pkg::C_IF_DROP:     step_d = flags_i.drop ? uw.target : step_inc;
        nes_pkg::C_IF_NOT_FULL: step_d = !flags_i.full ? uw.target : step_inc;
        nes_pkg::C_IF_BUDGET:   step_d = flags_i.budget ? uw.target : step_inc;
        nes_pkg::C_IF_MISS:     step_d = !flags_i.match ? uw.target : step_inc;
        nes_pkg::C_IF_END:      step_d = flags_i.is_end ? uw.target : step_inc;
        nes_pkg::C_IF_MATCH:    step_d = flags_i.match ? uw.target : step_inc;
        default:                step_d = nes_pkg::ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= nes_pkg::ST_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

FILE: src/nes_datapath.sv
// Datapath: mode, tick clock, event pointer, counters, pending result and
// output register, driven by one microcode op per cycle. Depends on nes_pkg.
`timescale 1ns / 1ps
module nes_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  nes_pkg::op_e              op_i,
  input  logic                      in_valid_i,
  input  logic [6:0]                note_i,
  input  logic                      note_on_i,
  input  logic [7:0]                velocity_i,
  output nes_pkg::flags_t           flags_o,
  output logic                      mem_we_o,
  output logic                      mem_re_o,
  output logic [nes_pkg::PTR_W-1:0] mem_addr_o,
  output logic [31:0]               mem_wdata_o,
  input  logic [31:0]               mem_rdata_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [2:0]                kind_o,
  output logic [6:0]                out_note_o,
  output logic [7:0]                out_velocity_o,
  output logic                      last_o
);

  nes_pkg::mode_e             mode_q, mode_d;
  logic [15:0]                clock_q, clock_d;
  logic [nes_pkg::PTR_W-1:0]  ptr_q, ptr_d;
  logic [nes_pkg::CNT_W-1:0]  stc_q, stc_d;
  logic [nes_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic                       seq_q, seq_d;
  logic                       pend_v_q, pend_v_d;
  logic [2:0]                 pend_kind_q;
  logic [6:0]                 pend_note_q;
  logic [7:0]                 pend_vel_q;
  logic [6:0]                 key_note_q;
  logic                       key_on_q;
  logic [7:0]                 key_vel_q;
  logic                       out_valid_q;
  logic [2:0]                 out_kind_q;
  logic [6:0]                 out_note_q;
  logic [7:0]                 out_vel_q;
  logic                       out_last_q;

  logic                       req;
  logic [2:0]                 req_kind;
  logic [6:0]                 req_note;
  logic [7:0]                 req_vel;
  logic                       req_last;
  logic                       out_free;
  logic                       stall;
  logic [7:0]                 vel_clamped;

  assign out_free    = !out_valid_q || out_ready_i;
  assign stall       = req && !out_free;
  assign vel_clamped = (key_vel_q == nes_pkg::END_VEL) ? nes_pkg::VEL_CLAMP : key_vel_q;

  always_comb begin
    req      = 1'b0;
    req_kind = pend_kind_q;
    req_note = pend_note_q;
    req_vel  = pend_vel_q;
    req_last = 1'b0;
    case (op_i)
      nes_pkg::OP_EMIT_FULL: begin
        req = 1'b1; req_kind = nes_pkg::KIND_FULL;
        req_note = '0; req_vel = '0; req_last = 1'b1;
      end
      nes_pkg::OP_EMIT_DROP: begin
        req = 1'b1; req_kind = nes_pkg::KIND_DROP;
        req_note = '0; req_vel = '0; req_last = 1'b1;
      end
      nes_pkg::OP_EMIT_WRAP: begin
        req = 1'b1; req_kind = nes_pkg::KIND_WRAP;
        req_note = '0; req_vel = '0; req_last = 1'b1;
      end
      nes_pkg::OP_PUSH_NOTE: req = pend_v_q;
      nes_pkg::OP_FLUSH_MID: req = pend_v_q;
      nes_pkg::OP_FLUSH_LAST: begin
        req = pend_v_q; req_last = 1'b1;
      end
      default: req = 1'b0;
    endcase
  end

  always_comb begin
    mode_d      = mode_q;
    clock_d     = clock_q;
    ptr_d       = ptr_q;
    stc_d       = stc_q;
    cnt_d       = cnt_q;
    seq_d       = seq_q;
    pend_v_d    = pend_v_q;
    mem_we_o    = 1'b0;
    mem_re_o    = 1'b0;
    mem_wdata_o = {clock_q, 1'b0, 7'd0, nes_pkg::END_VEL};
    case (op_i)
      nes_pkg::OP_TICK_REC: begin
        clock_d = clock_q + 16'd1;
        stc_d   = '0;
      end
      nes_pkg::OP_ZERO_CP: begin
        clock_d = '0;
        ptr_d   = '0;
      end
      nes_pkg::OP_START_REC: begin
        mode_d = nes_pkg::MODE_RECORD;
        clock_d = '0; ptr_d = '0; stc_d = '0; seq_d = 1'b0;
      end
      nes_pkg::OP_STOP: begin
        mode_d = nes_pkg::MODE_STOP;
        clock_d = '0; ptr_d = '0; stc_d = '0;
      end
      nes_pkg::OP_START_PLAY: begin
        mode_d = nes_pkg::MODE_PLAY;
        clock_d = '0; ptr_d = '0; stc_d = '0;
      end
      nes_pkg::OP_WR_END: begin
        mem_we_o = 1'b1;
        seq_d = 1'b1; mode_d = nes_pkg::MODE_STOP;
        clock_d = '0; ptr_d = '0; stc_d = '0;
      end
      nes_pkg::OP_WR_KEY: begin
        mem_we_o    = 1'b1;
        mem_wdata_o = {clock_q, key_on_q, key_note_q, vel_clamped};
        stc_d       = stc_q + nes_pkg::CNT_W'(1);
        // saturate so the end marker lands on the last entry
        ptr_d = (ptr_q == nes_pkg::PTR_LAST) ? ptr_q : ptr_q + nes_pkg::PTR_W'(1);
      end
      nes_pkg::OP_PLAY_INIT: begin
        cnt_d    = '0;
        pend_v_d = 1'b0;
      end
      nes_pkg::OP_READ: mem_re_o = 1'b1;
      nes_pkg::OP_PUSH_NOTE: begin
        if (!stall) begin
          pend_v_d = 1'b1;
          cnt_d    = cnt_q + nes_pkg::CNT_W'(1);
          ptr_d    = ptr_q + nes_pkg::PTR_W'(1);
        end
      end
      nes_pkg::OP_CLK_INC: clock_d = clock_q + 16'd1;
      nes_pkg::OP_FLUSH_MID, nes_pkg::OP_FLUSH_LAST: begin
        if (!stall) pend_v_d = 1'b0;
      end
      nes_pkg::OP_EMIT_WRAP: begin
        if (!stall) begin
          clock_d = '0;
          ptr_d   = '0;
        end
      end
      default: mode_d = mode_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= nes_pkg::MODE_STOP;
      clock_q     <= '0;
      ptr_q       <= '0;
      stc_q       <= '0;
      cnt_q       <= '0;
      seq_q       <= 1'b0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      mode_q   <= mode_d;
      clock_q  <= clock_d;
      ptr_q    <= ptr_d;
      stc_q    <= stc_d;
      cnt_q    <= cnt_d;
      seq_q    <= seq_d;
      pend_v_q <= pend_v_d;
      if (req && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i == nes_pkg::OP_ACCEPT && in_valid_i) begin
      key_note_q <= note_i;
      key_on_q   <= note_on_i;
      key_vel_q  <= velocity_i;
    end
    if (op_i == nes_pkg::OP_PUSH_NOTE && !stall) begin
      pend_kind_q <= mem_rdata_i[15] ? nes_pkg::KIND_NOTE_ON : nes_pkg::KIND_NOTE_OFF;
      pend_note_q <= mem_rdata_i[14:8];
      pend_vel_q  <= mem_rdata_i[7:0];
    end
    if (req && out_free) begin
      out_kind_q <= req_kind;
      out_note_q <= req_note;
      out_vel_q  <= req_vel;
      out_last_q <= req_last;
    end
  end

  assign mem_addr_o = ptr_q;

  assign flags_o.stall       = stall;
  assign flags_o.drop        = (stc_q >= nes_pkg::CNT_MAX);
  assign flags_o.full        = (ptr_q == nes_pkg::PTR_LAST);
  assign flags_o.budget      = (cnt_q >= nes_pkg::CNT_MAX);
  assign flags_o.match       = (mem_rdata_i[31:16] == clock_q);
  assign flags_o.is_end      = (mem_rdata_i[7:0] == nes_pkg::END_VEL);
  assign flags_o.seq_present = seq_q;
  assign flags_o.mode        = mode_q;

  assign out_valid_o    = out_valid_q;
  assign kind_o         = out_kind_q;
  assign out_note_o     = out_note_q;
  assign out_velocity_o = out_vel_q;
  assign last_o         = out_last_q;

endmodule

FILE: src/note_event_sequencer.sv
// Top level of the note event sequencer: sequencer, datapath and event memory.
// Depends on nes_pkg, nes_if, nes_sequencer, nes_datapath and nes_event_mem.
//
// Usage: evt_i carries command beats (tick, key event, start/end record, stop,
// start play); res_o carries result beats (note on/off, wrap, memory full,
// dropped event), the final beat of each command marked by last.
// A command is taken only while the microcode sits in its idle step, so the
// block works on one command at a time. Control commands and record ticks run
// their own step and return to idle; a recorded key event passes the key,
// write and check steps, a dropped one the key and drop steps, and one that
// fills the memory goes on to write the end marker and issues its full beat
// in the last step. A play tick walks the event memory event by event through
// the read, budget check, compare, end check and push steps, at most 64 events
// per tick; the shared address of the event memory and the step counter pace
// this walk. A note that a tick reads waits as the pending result until the
// next push or flush issues it. Reset clears mode, clock, pointer, counters
// and the take-present, pending and output valid flags; the event memory is
// not cleared and playback only reads entries that a finished recording wrote.
// A result beat waits in an output register; while the receiver stalls, the
// step that would emit the next beat holds.
`timescale 1ns / 1ps
module note_event_sequencer (
  input  logic      clk_i,
  input  logic      rst_ni,
  nes_in_if.sink    evt_i,
  nes_out_if.source res_o
);

  nes_pkg::op_e              op;
  nes_pkg::flags_t           flags;
  logic                      in_ready;
  logic                      mem_we;
  logic                      mem_re;
  logic [nes_pkg::PTR_W-1:0] mem_addr;
  logic [31:0]               mem_wdata;
  logic [31:0]               mem_rdata;

  assign evt_i.ready = in_ready;

  nes_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (evt_i.valid),
    .func_i     (evt_i.func),
    .flags_i    (flags),
    .op_o       (op),
    .in_ready_o (in_ready)
  );

  nes_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_i           (op),
    .in_valid_i     (evt_i.valid),
    .note_i         (evt_i.note),
    .note_on_i      (evt_i.note_on),
    .velocity_i     (evt_i.velocity),
    .flags_o        (flags),
    .mem_we_o       (mem_we),
    .mem_re_o       (mem_re),
    .mem_addr_o     (mem_addr),
    .mem_wdata_o    (mem_wdata),
    .mem_rdata_i    (mem_rdata),
    .out_valid_o    (res_o.valid),
    .out_ready_i    (res_o.ready),
    .kind_o         (res_o.kind),
    .out_note_o     (res_o.out_note),
    .out_velocity_o (res_o.out_velocity),
    .last_o         (res_o.last)
  );

  nes_event_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

endmodule

FILE: src/nes_checker.sv
// Port-level checks on the result channel of the note event sequencer,
// bound to the top level. Depends on nes_pkg and note_event_sequencer.
`timescale 1ns / 1ps
module nes_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [2:0] kind_i,
  input logic [6:0] out_note_i,
  input logic [7:0] out_velocity_i,
  input logic       last_i
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(kind_i) && $stable(out_note_i)
      && $stable(out_velocity_i) && $stable(last_i))
    else $error("result beat changed while stalled");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (kind_i == nes_pkg::KIND_WRAP || kind_i == nes_pkg::KIND_FULL
      || kind_i == nes_pkg::KIND_DROP) |-> last_i)
    else $error("status beat not marked last");

  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i != nes_pkg::KIND_NOTE_ON && kind_i != nes_pkg::KIND_NOTE_OFF
      |-> out_note_i == 7'd0 && out_velocity_i == 8'd0)
    else $error("status beat carries note data");

  a_no_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (kind_i == nes_pkg::KIND_NOTE_ON || kind_i == nes_pkg::KIND_NOTE_OFF)
      |-> out_velocity_i != nes_pkg::END_VEL)
    else $error("end marker played as a note");

endmodule

bind note_event_sequencer nes_checker u_nes_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (res_o.valid),
  .out_ready_i    (res_o.ready),
  .kind_i         (res_o.kind),
  .out_note_i     (res_o.out_note),
  .out_velocity_i (res_o.out_velocity),
  .last_i         (res_o.last)
);

FILE: verif/tb_note_event_sequencer.sv
// Self-checking testbench for note_event_sequencer: drives command beats and
// checks every result beat against a scoreboard with its own sequencer model.
// Depends on nes_pkg, nes_if and the note_event_sequencer RTL.
`timescale 1ns / 1ps
module tb_note_event_sequencer;

  localparam logic [2:0] FUNC_SPARE_A = 3'd6;
  localparam logic [2:0] FUNC_SPARE_B = 3'd7;
  localparam int unsigned RANDOM_CMDS = 260;

  typedef struct packed {
    logic [2:0] func;
    logic [6:0] note;
    logic       note_on;
    logic [7:0] velocity;
  } cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [6:0] note;
    logic [7:0] velocity;
    logic       last;
  } beat_t;

  class event_scoreboard;
    nes_pkg::mode_e            mode;
    logic [15:0]               clock_r;
    logic [nes_pkg::PTR_W-1:0] ptr;
    int unsigned               per_tick;
    bit                        present;
    logic [31:0]               mem [nes_pkg::EVENT_DEPTH];
    beat_t                     due_beats[$];
    int unsigned               errors;
    int unsigned               cmds_seen;
    int unsigned               beats_seen;
    int unsigned               kind_hits [8];

    function void clear();
      mode = nes_pkg::MODE_STOP;
      clock_r = '0;
      ptr = '0;
      per_tick = 0;
      present = 1'b0;
      errors = 0;
      cmds_seen = 0;
      beats_seen = 0;
      foreach (kind_hits[i]) kind_hits[i] = 0;
      foreach (mem[i]) mem[i] = '0;
    endfunction

    function void push_beat(logic [2:0] kind, logic [6:0] note, logic [7:0] vel);
      beat_t b;
      b = '{kind: kind, note: note, velocity: vel, last: 1'b0};
      due_beats.push_back(b);
    endfunction

    function void close_take();
      mem[ptr] = {clock_r, 8'h00, nes_pkg::END_VEL};
      present = 1'b1;
      mode = nes_pkg::MODE_STOP;
      clock_r = '0;
      ptr = '0;
      per_tick = 0;
    endfunction

    function void play_tick();
      int unsigned n;
      logic [31:0] e;
      n = 0;
      while (n < nes_pkg::MAX_PER_TICK) begin
        e = mem[ptr];
        if (e[31:16] != clock_r) break;
        if (e[7:0] == nes_pkg::END_VEL) begin
          push_beat(nes_pkg::KIND_WRAP, '0, '0);
          clock_r = '0;
          ptr = '0;
          return;
        end
        push_beat(e[15] ? nes_pkg::KIND_NOTE_ON : nes_pkg::KIND_NOTE_OFF, e[14:8], e[7:0]);
        n++;
        ptr = ptr + 1'b1;
      end
      if (n >= nes_pkg::MAX_PER_TICK && mem[ptr][31:16] == clock_r) return;
      clock_r = clock_r + 16'd1;
    endfunction

    function void record_key(cmd_t c);
      logic [7:0] vel;
      if (per_tick >= nes_pkg::MAX_PER_TICK) begin
        push_beat(nes_pkg::KIND_DROP, '0, '0);
        return;
      end
      vel = (c.velocity > nes_pkg::VEL_CLAMP) ? nes_pkg::VEL_CLAMP : c.velocity;
      mem[ptr] = {clock_r, c.note_on, c.note, vel};
      per_tick++;
      ptr = ptr + 1'b1;
      if (ptr >= nes_pkg::PTR_LAST || ptr == '0) begin
        if (ptr == '0) ptr = nes_pkg::PTR_LAST;
        close_take();
        push_beat(nes_pkg::KIND_FULL, '0, '0);
      end
    endfunction

    function void apply_command(cmd_t c);
      int unsigned n_prev;
      beat_t tail;
      n_prev = due_beats.size();
      cmds_seen++;
      case (c.func)
        nes_pkg::FUNC_TICK: begin
          if (mode == nes_pkg::MODE_PLAY) begin
            play_tick();
          end else if (mode == nes_pkg::MODE_RECORD) begin
            clock_r = clock_r + 16'd1;
            per_tick = 0;
          end else begin
            clock_r = '0;
            ptr = '0;
          end
        end
        nes_pkg::FUNC_KEY: begin
          if (mode == nes_pkg::MODE_RECORD) record_key(c);
        end
        nes_pkg::FUNC_START_REC: begin
          mode = nes_pkg::MODE_RECORD;
          clock_r = '0;
          ptr = '0;
          per_tick = 0;
          present = 1'b0;
        end
        nes_pkg::FUNC_END_REC: begin
          if (mode == nes_pkg::MODE_RECORD) close_take();
        end
        nes_pkg::FUNC_STOP: begin
          mode = nes_pkg::MODE_STOP;
          clock_r = '0;
          ptr = '0;
          per_tick = 0;
        end
        nes_pkg::FUNC_START_PLAY: begin
          if (present) begin
            mode = nes_pkg::MODE_PLAY;
            clock_r = '0;
            ptr = '0;
            per_tick = 0;
          end
        end
        default: ;
      endcase
      if (due_beats.size() > n_prev) begin
        tail = due_beats.pop_back();
        tail.last = 1'b1;
        due_beats.push_back(tail);
      end
    endfunction

    function void flag(string what, logic [7:0] want, logic [7:0] got);
      errors++;
      if (errors <= 40)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    endfunction

    function void check_beat(beat_t got);
      beat_t want;
      beats_seen++;
      kind_hits[got.kind]++;
      if (due_beats.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t: unexpected beat, expected none, actual kind %0d note %0d vel %0d",
                   $time, got.kind, got.note, got.velocity);
        return;
      end
      want = due_beats.pop_front();
      if (got.kind !== want.kind) flag("kind", want.kind, got.kind);
      if (got.note !== want.note) flag("out_note", want.note, got.note);
      if (got.velocity !== want.velocity) flag("out_velocity", want.velocity, got.velocity);
      if (got.last !== want.last) flag("last", want.last, got.last);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   tx_calm;
  bit   rx_calm;
  int   hold_req;

  event_scoreboard sb = new();

  nes_in_if  evt_if ();
  nes_out_if res_if ();

  note_event_sequencer dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .evt_i  (evt_if),
    .res_o  (res_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(99, 0);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  function automatic logic [7:0] rand_vel();
    int r;
    r = $urandom_range(9, 0);
    if (r == 0) return 8'hFF;
    if (r == 1) return 8'hFE;
    if (r == 2) return 8'h00;
    return 8'($urandom_range(255, 0));
  endfunction

  function automatic cmd_t mk(logic [2:0] f, logic [6:0] n = '0, logic on = 1'b0,
                              logic [7:0] v = '0);
    cmd_t c;
    c = '{func: f, note: n, note_on: on, velocity: v};
    return c;
  endfunction

  function automatic cmd_t rand_key();
    return mk(nes_pkg::FUNC_KEY, 7'($urandom_range(127, 0)), 1'($urandom_range(1, 0)),
              rand_vel());
  endfunction

  function automatic cmd_t rand_any();
    return mk(3'($urandom_range(7, 0)), 7'($urandom_range(127, 0)),
              1'($urandom_range(1, 0)), rand_vel());
  endfunction

  // hold valid until the block takes the beat
  task automatic send(cmd_t c);
    int gap;
    gap = pick_gap(tx_calm);
    for (int i = 0; i < gap; i++) begin
      @(negedge clk);
      evt_if.valid = 1'b0;
    end
    @(negedge clk);
    evt_if.valid    = 1'b1;
    evt_if.func     = c.func;
    evt_if.note     = c.note;
    evt_if.note_on  = c.note_on;
    evt_if.velocity = c.velocity;
    do @(posedge clk); while (evt_if.ready !== 1'b1);
    sb.apply_command(c);
  endtask

  initial begin
    int stall_left;
    beat_t got;
    int r;
    stall_left = 0;
    res_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        stall_left = hold_req;
        hold_req = 0;
      end
      if (stall_left > 0) begin
        res_if.ready = 1'b0;
        stall_left--;
      end else if (rx_calm) begin
        res_if.ready = 1'b1;
      end else begin
        r = $urandom_range(99, 0);
        if (r < 70) begin
          res_if.ready = 1'b1;
        end else begin
          res_if.ready = 1'b0;
          stall_left = (r < 95) ? $urandom_range(2, 0) : $urandom_range(29, 9);
        end
      end
      @(posedge clk);
      if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
        got = '{kind: res_if.kind, note: res_if.out_note, velocity: res_if.out_velocity,
                last: res_if.last};
        sb.check_beat(got);
      end
    end
  end

  task automatic run_directed();
    send(mk(nes_pkg::FUNC_TICK));
    send(mk(nes_pkg::FUNC_KEY, 7'd127, 1'b1, 8'hFF));
    send(mk(nes_pkg::FUNC_START_PLAY));
    send(mk(nes_pkg::FUNC_END_REC));
    send(mk(FUNC_SPARE_A, 7'h55, 1'b1, 8'hAA));
    send(mk(FUNC_SPARE_B, 7'h2A, 1'b0, 8'h55));
    send(mk(nes_pkg::FUNC_START_REC));
    send(mk(nes_pkg::FUNC_KEY, 7'd0, 1'b0, 8'h00));
    send(mk(nes_pkg::FUNC_KEY, 7'd127, 1'b1, 8'hFF));
    send(mk(nes_pkg::FUNC_KEY, 7'd85, 1'b1, 8'hFE));
    send(mk(nes_pkg::FUNC_KEY, 7'd42, 1'b0, 8'h01));
    send(mk(nes_pkg::FUNC_TICK));
    send(mk(nes_pkg::FUNC_KEY, 7'd1, 1'b1, 8'h80));
    send(mk(nes_pkg::FUNC_TICK));
    send(mk(nes_pkg::FUNC_TICK));
    send(mk(nes_pkg::FUNC_END_REC));
    send(mk(nes_pkg::FUNC_START_PLAY));
    repeat (5) send(mk(nes_pkg::FUNC_TICK));
    send(mk(nes_pkg::FUNC_STOP));
    send(mk(nes_pkg::FUNC_TICK));
    send(mk(nes_pkg::FUNC_START_REC));
    send(mk(nes_pkg::FUNC_KEY, 7'd60, 1'b1, 8'h40));
    send(mk(nes_pkg::FUNC_STOP));
    send(mk(nes_pkg::FUNC_START_PLAY));
  endtask

  // overfill one tick, close in the same tick, then stall the receiver
  task automatic run_pressure();
    send(mk(nes_pkg::FUNC_START_REC));
    repeat (nes_pkg::MAX_PER_TICK + 2) send(rand_key());
    send(mk(nes_pkg::FUNC_END_REC));
    send(mk(nes_pkg::FUNC_START_PLAY));
    hold_req = 400;
    repeat (4) send(mk(nes_pkg::FUNC_TICK));
    send(mk(nes_pkg::FUNC_STOP));
  endtask

  task automatic run_take();
    int n_ticks;
    int keys;
    int r;
    send(mk(nes_pkg::FUNC_START_REC));
    n_ticks = $urandom_range(6, 1);
    for (int t = 0; t < n_ticks; t++) begin
      keys = ($urandom_range(29, 0) == 0) ? $urandom_range(68, 62) : $urandom_range(4, 0);
      repeat (keys) send(rand_key());
      if ($urandom_range(9, 0) == 0) send(mk(nes_pkg::FUNC_START_PLAY));
      if (t != n_ticks - 1 || $urandom_range(3, 0) != 0) send(mk(nes_pkg::FUNC_TICK));
    end
    r = $urandom_range(99, 0);
    if (r < 80) send(mk(nes_pkg::FUNC_END_REC));
    else if (r < 92) send(mk(nes_pkg::FUNC_STOP));
    else return;
    send(mk(nes_pkg::FUNC_START_PLAY));
    repeat (n_ticks + $urandom_range(n_ticks + 4, 1)) begin
      if ($urandom_range(7, 0) == 0) send(rand_key());
      send(mk(nes_pkg::FUNC_TICK));
    end
    if ($urandom_range(1, 0) == 0) send(mk(nes_pkg::FUNC_STOP));
  endtask

  task automatic run_random();
    int unsigned stop_at;
    stop_at = sb.cmds_seen + RANDOM_CMDS;
    while (sb.cmds_seen < stop_at) begin
      rx_calm = ($urandom_range(7, 0) == 0);
      tx_calm = ($urandom_range(7, 0) == 0);
      if ($urandom_range(4, 0) == 0) repeat ($urandom_range(4, 1)) send(rand_any());
      else run_take();
    end
    rx_calm = 1'b0;
    tx_calm = 1'b0;
  endtask

  initial begin
    int waited;
    hold_req = 0;
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    evt_if.valid    = 1'b0;
    evt_if.func     = nes_pkg::FUNC_TICK;
    evt_if.note     = '0;
    evt_if.note_on  = 1'b0;
    evt_if.velocity = '0;
    rst_n = 1'b0;
    sb.clear();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    run_directed();
    run_pressure();
    run_random();

    @(negedge clk);
    evt_if.valid = 1'b0;
    waited = 0;
    while (sb.due_beats.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (300) @(posedge clk);
    if (sb.due_beats.size() != 0) begin
      $display("%0t: %0d expected beats never arrived", $time, sb.due_beats.size());
      sb.errors += sb.due_beats.size();
    end

    $display("run covered %0d commands and %0d result beats", sb.cmds_seen, sb.beats_seen);
    $display("  note on %0d, note off %0d, wrap %0d, full stop %0d, dropped %0d",
             sb.kind_hits[nes_pkg::KIND_NOTE_ON], sb.kind_hits[nes_pkg::KIND_NOTE_OFF],
             sb.kind_hits[nes_pkg::KIND_WRAP], sb.kind_hits[nes_pkg::KIND_FULL],
             sb.kind_hits[nes_pkg::KIND_DROP]);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
